FILE: rtl/msseq_pkg.sv
// Shared types and constants of the multi-voice step sequencer.
package msseq_pkg;

	localparam int PATTERN_W = 16;
	localparam int STEP_W    = 5;
	localparam int NOTE_W    = 7;
	localparam int VEL_W     = 7;
	localparam int OPC_W     = 2;
	localparam int VOICE_W   = 4;
	localparam int SKIP_W    = 5;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// Steps that the hit mask covers
	localparam int HIT_STEPS = 16;

	localparam logic [STEP_W-1:0] STEP_NONE = 5'd16;

	// Opcodes
	localparam logic [OPC_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OPC_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OPC_W-1:0] OP_RESET = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_BASE_NOTE  = 2'd0;
	localparam logic [1:0] REG_STRONG_VEL = 2'd1;
	localparam logic [1:0] REG_WEAK_VEL   = 2'd2;
	localparam logic [1:0] REG_PLAIN_VEL  = 2'd3;

	// Register reset values
	localparam logic [NOTE_W-1:0] BASE_NOTE_RST  = 7'd60;
	localparam logic [VEL_W-1:0]  STRONG_VEL_RST = 7'd127;
	localparam logic [VEL_W-1:0]  WEAK_VEL_RST   = 7'd80;
	localparam logic [VEL_W-1:0]  PLAIN_VEL_RST  = 7'd60;

	typedef struct packed {
		logic [NOTE_W-1:0] base_note;
		logic [VEL_W-1:0]  strong_vel;
		logic [VEL_W-1:0]  weak_vel;
		logic [VEL_W-1:0]  plain_vel;
	} cfg_t;

	typedef enum logic [2:0] {
		BANK_NOP,
		BANK_LOAD,
		BANK_CLEAR,
		BANK_ZERO,
		BANK_ADVANCE
	} bank_op_t;

endpackage

FILE: rtl/msseq_regs.sv
// APB configuration registers of the step sequencer.
module msseq_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msseq_pkg::ADDR_W-1:0]  paddr,
	input  logic [msseq_pkg::DATA_W-1:0]  pwdata,
	output logic [msseq_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output msseq_pkg::cfg_t               cfg
);

	msseq_pkg::cfg_t cfg_q;
	logic [1:0]      reg_idx;
	logic            wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write the addressed register in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_note  <= msseq_pkg::BASE_NOTE_RST;
			cfg_q.strong_vel <= msseq_pkg::STRONG_VEL_RST;
			cfg_q.weak_vel   <= msseq_pkg::WEAK_VEL_RST;
			cfg_q.plain_vel  <= msseq_pkg::PLAIN_VEL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				msseq_pkg::REG_BASE_NOTE:  cfg_q.base_note  <= pwdata[msseq_pkg::NOTE_W-1:0];
				msseq_pkg::REG_STRONG_VEL: cfg_q.strong_vel <= pwdata[msseq_pkg::VEL_W-1:0];
				msseq_pkg::REG_WEAK_VEL:   cfg_q.weak_vel   <= pwdata[msseq_pkg::VEL_W-1:0];
				msseq_pkg::REG_PLAIN_VEL:  cfg_q.plain_vel  <= pwdata[msseq_pkg::VEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (reg_idx)
			msseq_pkg::REG_BASE_NOTE:  prdata = msseq_pkg::DATA_W'(cfg_q.base_note);
			msseq_pkg::REG_STRONG_VEL: prdata = msseq_pkg::DATA_W'(cfg_q.strong_vel);
			msseq_pkg::REG_WEAK_VEL:   prdata = msseq_pkg::DATA_W'(cfg_q.weak_vel);
			msseq_pkg::REG_PLAIN_VEL:  prdata = msseq_pkg::DATA_W'(cfg_q.plain_vel);
			default:                   prdata = '0;
		endcase
	end

endmodule

FILE: rtl/msseq_bank.sv
// Per-voice state: hit masks, step counters, loop lengths and accent steps.
module msseq_bank #(
	parameter int VOICES    = 16,
	parameter int MAX_STEPS = 16,
	parameter int VW        = (VOICES > 1) ? $clog2(VOICES) : 1,
	parameter int CW        = $clog2(MAX_STEPS),
	parameter int LW        = $clog2(MAX_STEPS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msseq_pkg::bank_op_t              op,
	input  logic [VW-1:0]                    wr_idx,
	input  logic [msseq_pkg::PATTERN_W-1:0]  ld_pattern,
	input  logic [LW-1:0]                    ld_len,
	input  logic [msseq_pkg::STEP_W-1:0]     ld_strong,
	input  logic [msseq_pkg::STEP_W-1:0]     ld_weak,
	input  logic [VW-1:0]                    rd_idx,
	input  logic [CW-1:0]                    nxt_cnt,
	output logic [msseq_pkg::PATTERN_W-1:0]  rd_pattern,
	output logic [CW-1:0]                    rd_cnt,
	output logic [LW-1:0]                    rd_len,
	output logic [msseq_pkg::STEP_W-1:0]     rd_strong,
	output logic [msseq_pkg::STEP_W-1:0]     rd_weak
);

	logic [msseq_pkg::PATTERN_W-1:0] pattern_q [VOICES];
	logic [CW-1:0]                   cnt_q     [VOICES];
	logic [LW-1:0]                   len_q     [VOICES];
	logic [msseq_pkg::STEP_W-1:0]    strong_q  [VOICES];
	logic [msseq_pkg::STEP_W-1:0]    weak_q    [VOICES];

	// Apply one edit or counter update a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				pattern_q[v] <= '0;
				cnt_q[v]     <= '0;
				len_q[v]     <= '0;
				strong_q[v]  <= msseq_pkg::STEP_NONE;
				weak_q[v]    <= msseq_pkg::STEP_NONE;
			end
		end else begin
			unique case (op)
				msseq_pkg::BANK_LOAD: begin
					pattern_q[wr_idx] <= ld_pattern;
					cnt_q[wr_idx]     <= '0;
					len_q[wr_idx]     <= ld_len;
					strong_q[wr_idx]  <= ld_strong;
					weak_q[wr_idx]    <= ld_weak;
				end
				msseq_pkg::BANK_CLEAR: begin
					pattern_q[wr_idx] <= '0;
					cnt_q[wr_idx]     <= '0;
				end
				msseq_pkg::BANK_ZERO: begin
					for (int v = 0; v < VOICES; v++) begin
						pattern_q[v] <= '0;
						cnt_q[v]     <= '0;
					end
				end
				msseq_pkg::BANK_ADVANCE: cnt_q[rd_idx] <= nxt_cnt;
				default: ;
			endcase
		end
	end

	// Read the voice under the walk
	assign rd_pattern = pattern_q[rd_idx];
	assign rd_cnt     = cnt_q[rd_idx];
	assign rd_len     = len_q[rd_idx];
	assign rd_strong  = strong_q[rd_idx];
	assign rd_weak    = weak_q[rd_idx];

endmodule

FILE: rtl/msseq_walk.sv
// Sequencer that walks the voices on a tick and drives the result channel.
module msseq_walk #(
	parameter int VOICES    = 16,
	parameter int MAX_STEPS = 16,
	parameter int VW        = (VOICES > 1) ? $clog2(VOICES) : 1,
	parameter int CW        = $clog2(MAX_STEPS),
	parameter int LW        = $clog2(MAX_STEPS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msseq_pkg::cfg_t                  cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [msseq_pkg::OPC_W-1:0]      opcode,
	input  logic [msseq_pkg::VOICE_W-1:0]    voice,
	input  logic [msseq_pkg::STEP_W-1:0]     loop_length,
	input  logic [msseq_pkg::SKIP_W-1:0]     skip_voice,
	output msseq_pkg::bank_op_t              bank_op,
	output logic [VW-1:0]                    wr_idx,
	output logic [LW-1:0]                    ld_len,
	output logic [VW-1:0]                    rd_idx,
	output logic [CW-1:0]                    nxt_cnt,
	input  logic [msseq_pkg::PATTERN_W-1:0]  rd_pattern,
	input  logic [CW-1:0]                    rd_cnt,
	input  logic [LW-1:0]                    rd_len,
	input  logic [msseq_pkg::STEP_W-1:0]     rd_strong,
	input  logic [msseq_pkg::STEP_W-1:0]     rd_weak,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [msseq_pkg::NOTE_W-1:0]     note_number,
	output logic [msseq_pkg::VEL_W-1:0]      velocity,
	output logic                             last_of_run
);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_t;

	localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

	state_t                          state_q;
	logic [VW-1:0]                   walk_q;
	logic [msseq_pkg::SKIP_W-1:0]    skip_q;
	logic                            pend_valid_q;
	logic [msseq_pkg::NOTE_W-1:0]    pend_note_q;
	logic [msseq_pkg::VEL_W-1:0]     pend_vel_q;
	logic                            out_valid_q;
	logic [msseq_pkg::NOTE_W-1:0]    out_note_q;
	logic [msseq_pkg::VEL_W-1:0]     out_vel_q;
	logic                            out_last_q;

	logic                            accept;
	logic                            voice_ok;
	logic [31:0]                     cnt_ext;
	logic                            hit;
	logic                            skipped;
	logic                            live_hit;
	logic [msseq_pkg::VEL_W-1:0]     hit_vel;
	logic [msseq_pkg::NOTE_W-1:0]    hit_note;
	logic                            out_free;
	logic                            stall;
	logic [LW-1:0]                   cnt_inc;
	logic                            push_mid;
	logic                            push_end;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign voice_ok = 32'(voice) < VOICES;
	assign wr_idx   = VW'(voice);
	assign rd_idx   = walk_q;

	// Clamp the loaded loop length to the step range
	assign ld_len = (32'(loop_length) > MAX_STEPS) ? LW'(MAX_STEPS) : LW'(loop_length);

	// Evaluate the voice under the walk
	assign cnt_ext  = 32'(rd_cnt);
	assign hit      = (cnt_ext < msseq_pkg::HIT_STEPS) && rd_pattern[cnt_ext[3:0]];
	assign skipped  = 32'(skip_q) == 32'(walk_q);
	assign live_hit = hit && !skipped;
	assign hit_note = cfg.base_note + msseq_pkg::NOTE_W'(walk_q);

	always_comb begin
		if (32'(rd_strong) == cnt_ext) begin
			hit_vel = cfg.strong_vel;
		end else if (32'(rd_weak) == cnt_ext) begin
			hit_vel = cfg.weak_vel;
		end else begin
			hit_vel = cfg.plain_vel;
		end
	end

	// Advance the counter, wrapping at the loop length
	assign cnt_inc = LW'(rd_cnt) + LW'(1);
	assign nxt_cnt = (cnt_inc >= rd_len) ? '0 : CW'(cnt_inc);

	// Hold the walk while a new hit cannot push the pending one out
	assign out_free = !out_valid_q || out_ready;
	assign stall    = live_hit && pend_valid_q && !out_free;

	// Move the pending result out on a later hit or at the end of the walk
	assign push_mid = (state_q == S_WALK) && !stall && live_hit && pend_valid_q;
	assign push_end = (state_q == S_FLUSH) && pend_valid_q && out_free;

	// Pick the bank operation for this cycle
	always_comb begin
		bank_op = msseq_pkg::BANK_NOP;
		if (accept) begin
			unique case (opcode)
				msseq_pkg::OP_LOAD:
					if (voice_ok) bank_op = msseq_pkg::BANK_LOAD;
				msseq_pkg::OP_CLEAR:
					if (voice_ok) bank_op = msseq_pkg::BANK_CLEAR;
				msseq_pkg::OP_RESET: bank_op = msseq_pkg::BANK_ZERO;
				default: ;
			endcase
		end else if (state_q == S_WALK && !stall && !skipped) begin
			bank_op = msseq_pkg::BANK_ADVANCE;
		end
	end

	// Step the walk and move results through the pending and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			walk_q       <= '0;
			skip_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_mid || push_end) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == msseq_pkg::OP_TICK) begin
						skip_q  <= skip_voice;
						walk_q  <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!stall) begin
						if (live_hit) begin
							if (pend_valid_q) begin
								out_note_q  <= pend_note_q;
								out_vel_q   <= pend_vel_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_note_q  <= hit_note;
							pend_vel_q   <= hit_vel;
						end
						if (walk_q == LAST_VOICE) begin
							state_q <= S_FLUSH;
						end else begin
							walk_q <= walk_q + VW'(1);
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_note_q   <= pend_note_q;
						out_vel_q    <= pend_vel_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign note_number = out_note_q;
	assign velocity    = out_vel_q;
	assign last_of_run = out_last_q;

endmodule

FILE: rtl/multi_voice_step_sequencer_core.sv
// Load, clear and reset take effect at acceptance; the next item can be taken in the cycle after.
// A tick walks one voice per cycle, unless a result stall holds it, through the shared evaluate
// and advance unit: acceptance, a walk over each voice, then a flush; no item is taken meanwhile.
// A result is registered at the edge that evaluates the next hit, or at the flush edge for the
// last hit of the tick. Reset (arst_n low, asynchronous) clears all voices, sets no accents,
// loads the register defaults and empties the result channel.
module multi_voice_step_sequencer_core #(
	parameter int VOICES    = 16,
	parameter int MAX_STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [msseq_pkg::ADDR_W-1:0]     paddr,
	input  logic [msseq_pkg::DATA_W-1:0]     pwdata,
	output logic [msseq_pkg::DATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [msseq_pkg::OPC_W-1:0]      opcode,
	input  logic [msseq_pkg::VOICE_W-1:0]    voice,
	input  logic [msseq_pkg::PATTERN_W-1:0]  pattern,
	input  logic [msseq_pkg::STEP_W-1:0]     loop_length,
	input  logic [msseq_pkg::STEP_W-1:0]     strong_step,
	input  logic [msseq_pkg::STEP_W-1:0]     weak_step,
	input  logic [msseq_pkg::SKIP_W-1:0]     skip_voice,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [msseq_pkg::NOTE_W-1:0]     note_number,
	output logic [msseq_pkg::VEL_W-1:0]      velocity,
	output logic                             last_of_run
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(MAX_STEPS);
	localparam int LW = $clog2(MAX_STEPS + 1);

	msseq_pkg::cfg_t                 cfg;
	msseq_pkg::bank_op_t             bank_op;
	logic [VW-1:0]                   wr_idx;
	logic [VW-1:0]                   rd_idx;
	logic [LW-1:0]                   ld_len;
	logic [CW-1:0]                   nxt_cnt;
	logic [msseq_pkg::PATTERN_W-1:0] rd_pattern;
	logic [CW-1:0]                   rd_cnt;
	logic [LW-1:0]                   rd_len;
	logic [msseq_pkg::STEP_W-1:0]    rd_strong;
	logic [msseq_pkg::STEP_W-1:0]    rd_weak;

	msseq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msseq_bank #(
		.VOICES    (VOICES),
		.MAX_STEPS (MAX_STEPS),
		.VW        (VW),
		.CW        (CW),
		.LW        (LW)
	) u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (bank_op),
		.wr_idx     (wr_idx),
		.ld_pattern (pattern),
		.ld_len     (ld_len),
		.ld_strong  (strong_step),
		.ld_weak    (weak_step),
		.rd_idx     (rd_idx),
		.nxt_cnt    (nxt_cnt),
		.rd_pattern (rd_pattern),
		.rd_cnt     (rd_cnt),
		.rd_len     (rd_len),
		.rd_strong  (rd_strong),
		.rd_weak    (rd_weak)
	);

	msseq_walk #(
		.VOICES    (VOICES),
		.MAX_STEPS (MAX_STEPS),
		.VW        (VW),
		.CW        (CW),
		.LW        (LW)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.voice       (voice),
		.loop_length (loop_length),
		.skip_voice  (skip_voice),
		.bank_op     (bank_op),
		.wr_idx      (wr_idx),
		.ld_len      (ld_len),
		.rd_idx      (rd_idx),
		.nxt_cnt     (nxt_cnt),
		.rd_pattern  (rd_pattern),
		.rd_cnt      (rd_cnt),
		.rd_len      (rd_len),
		.rd_strong   (rd_strong),
		.rd_weak     (rd_weak),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.note_number (note_number),
		.velocity    (velocity),
		.last_of_run (last_of_run)
	);

endmodule

FILE: rtl/msseq_checker.sv
// Port-level checks of the step sequencer and their binding to the top level.
module msseq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [msseq_pkg::OPC_W-1:0]   opcode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [msseq_pkg::NOTE_W-1:0]  note_number,
	input logic [msseq_pkg::VEL_W-1:0]   velocity,
	input logic                          last_of_run
);

	// A stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(note_number) && $stable(velocity)
			&& $stable(last_of_run))
		else $error("stalled result changed");

	// An edit item finishes at once
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode != msseq_pkg::OP_TICK |=> in_ready)
		else $error("edit item did not release the input");

	// A tick occupies the block while it walks
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == msseq_pkg::OP_TICK |=> !in_ready)
		else $error("tick did not start a walk");

	// A result that is not the last of its run means the walk still goes on
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("input taken before the run ended");

endmodule

bind multi_voice_step_sequencer_core msseq_checker u_msseq_checker (.*);
